>>> hw/rtl/sls_pkg.sv
// Shared types, codes and constants of the sensor lifecycle supervisor.
package sls_pkg;

    localparam int TIME_W  = 32;
    localparam int ALLOW_W = 8;
    localparam int COUNT_W = 9;
    localparam int IDX_W   = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    localparam logic [1:0] ST_UNINIT  = 2'd0;
    localparam logic [1:0] ST_INITING = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_LOST    = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_BUS   = 2'd1;
    localparam logic [1:0] ERR_DECAY = 2'd2;
    localparam logic [1:0] ERR_LOST  = 2'd3;

    localparam logic [IDX_W-1:0] CFG_MIN_INTERVAL  = 8'd0;
    localparam logic [IDX_W-1:0] CFG_INIT_INTERVAL = 8'd1;
    localparam logic [IDX_W-1:0] CFG_DECAY_TIME    = 8'd2;
    localparam logic [IDX_W-1:0] CFG_ALLOWED_ERR   = 8'd3;

    localparam logic [ALLOW_W-1:0] ALLOWED_ERR_RESET = 8'd3;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              init_failed;
        logic              measure_failed;
    } in_t;

    typedef struct packed {
        logic [1:0] state_after;
        logic [1:0] error_code;
        logic       init_attempted;
        logic       measure_taken;
    } out_t;

    typedef struct packed {
        logic [TIME_W-1:0]  min_interval_ms;
        logic [TIME_W-1:0]  init_interval_ms;
        logic [TIME_W-1:0]  decay_time_ms;
        logic [ALLOW_W-1:0] allowed_errors;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         life_state;
        logic [TIME_W-1:0]  last_stamp_ms;
        logic [COUNT_W-1:0] init_error_count;
        logic [COUNT_W-1:0] measure_error_count;
    } lstate_t;

endpackage

>>> hw/rtl/sls_step.sv
// Next-state and result logic for one update tick of the supervisor.
module sls_step (
    input  sls_pkg::cfg_t    cfg,
    input  sls_pkg::lstate_t cur,
    input  sls_pkg::in_t     tick,
    output sls_pkg::lstate_t nxt,
    output sls_pkg::out_t    res
);

    function automatic logic [sls_pkg::COUNT_W-1:0] bump(
        input logic [sls_pkg::COUNT_W-1:0] c
    );
        bump = (c < sls_pkg::COUNT_MAX) ? c + 1'b1 : sls_pkg::COUNT_MAX;
    endfunction

    logic [sls_pkg::TIME_W-1:0] elapsed;
    logic [1:0]                 err;
    logic                       tried;
    logic                       taken;
    logic [sls_pkg::COUNT_W-1:0] allow_ext;
    sls_pkg::lstate_t            mid;

    // Timestamp difference wraps modulo 2^32.
    assign elapsed   = tick.now_ms - cur.last_stamp_ms;
    assign allow_ext = {1'b0, cfg.allowed_errors};

    always_comb begin
        mid   = cur;
        err   = sls_pkg::ERR_NONE;
        tried = 1'b0;
        taken = 1'b0;
        unique case (cur.life_state)
            sls_pkg::ST_UNINIT: begin
                tried = 1'b1;
                if (tick.init_failed) begin
                    err = sls_pkg::ERR_BUS;
                    mid.init_error_count = bump(cur.init_error_count);
                end else begin
                    mid.init_error_count = '0;
                    mid.last_stamp_ms    = tick.now_ms;
                    mid.life_state       = (cfg.init_interval_ms != '0) ?
                                           sls_pkg::ST_INITING : sls_pkg::ST_RUNNING;
                end
            end
            sls_pkg::ST_INITING: begin
                // Warm-up also counts as passed while now is below the interval.
                if ((tick.now_ms < cfg.init_interval_ms) ||
                    (elapsed >= cfg.init_interval_ms)) begin
                    mid.life_state    = sls_pkg::ST_RUNNING;
                    mid.last_stamp_ms = tick.now_ms;
                end
            end
            sls_pkg::ST_RUNNING: begin
                if ((cfg.decay_time_ms != '0) && (elapsed > cfg.decay_time_ms)) begin
                    mid.life_state = sls_pkg::ST_UNINIT;
                    err            = sls_pkg::ERR_DECAY;
                end else if (elapsed >= cfg.min_interval_ms) begin
                    if (tick.measure_failed) begin
                        err = sls_pkg::ERR_BUS;
                    end else begin
                        mid.last_stamp_ms = tick.now_ms;
                        taken             = 1'b1;
                    end
                end
                if (err != sls_pkg::ERR_NONE) begin
                    mid.measure_error_count = bump(cur.measure_error_count);
                end else begin
                    mid.measure_error_count = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        nxt                = mid;
        res.state_after    = mid.life_state;
        res.error_code     = err;
        res.init_attempted = tried;
        res.measure_taken  = taken;
        if ((mid.init_error_count > allow_ext) ||
            (mid.measure_error_count > allow_ext)) begin
            nxt.life_state  = sls_pkg::ST_LOST;
            res.state_after = sls_pkg::ST_LOST;
            res.error_code  = sls_pkg::ERR_LOST;
        end
    end

endmodule

>>> hw/rtl/sensor_lifecycle_supervisor.sv
// Top level of the sensor lifecycle supervisor: channels, registers and config.
//
// Usage: each beat on the s_ channel is one update tick carrying the current
// millisecond time and the outcomes that the sensor's init step and its
// measurement would report. For every tick exactly one result beat leaves on
// the m_ channel with the lifecycle state after the tick, an error code and
// two flags telling whether an init step was tried and a measurement taken.
// Registers are written over the cfg_ channel, which is always ready; writes
// are expected only while no tick is in flight, and unknown indexes are
// dropped.
// The edge that accepts a tick loads the input register; at the edge on which
// the result register is empty or being drained, the tick is evaluated against
// the stored lifecycle state and the result register is loaded, raising m_valid.
// Throughput is one tick per cycle while the receiver keeps m_ready high; the
// lifecycle state and counters update in the same cycle that loads the result,
// so the following tick sees them at once.
// On reset the state returns to uninitialized, the timestamp and both error
// counters clear, intervals return to zero and the error allowance to three.
// When the receiver stalls, the result register holds its beat and the input
// register takes one more tick; s_ready then drops until m_ready returns.
module sensor_lifecycle_supervisor (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  sls_pkg::in_t                      s_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output sls_pkg::out_t                     m_data,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sls_pkg::IDX_W-1:0]         cfg_index,
    input  logic [sls_pkg::TIME_W-1:0]        cfg_data
);

    sls_pkg::cfg_t    cfg_reg;
    sls_pkg::lstate_t life_reg;
    sls_pkg::lstate_t life_next;
    sls_pkg::in_t     in_data_reg;
    logic             in_valid_reg;
    sls_pkg::out_t    out_data_reg;
    sls_pkg::out_t    out_next;
    logic             out_valid_reg;
    logic             advance;

    // A tick moves forward when the result register is empty or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    sls_step u_step (
        .cfg  (cfg_reg),
        .cur  (life_reg),
        .tick (in_data_reg),
        .nxt  (life_next),
        .res  (out_next)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_interval_ms  <= '0;
            cfg_reg.init_interval_ms <= '0;
            cfg_reg.decay_time_ms    <= '0;
            cfg_reg.allowed_errors   <= sls_pkg::ALLOWED_ERR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sls_pkg::CFG_MIN_INTERVAL:  cfg_reg.min_interval_ms  <= cfg_data;
                sls_pkg::CFG_INIT_INTERVAL: cfg_reg.init_interval_ms <= cfg_data;
                sls_pkg::CFG_DECAY_TIME:    cfg_reg.decay_time_ms    <= cfg_data;
                sls_pkg::CFG_ALLOWED_ERR: begin
                    cfg_reg.allowed_errors <= cfg_data[sls_pkg::ALLOW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Lifecycle state and handshake control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            life_reg.life_state          <= sls_pkg::ST_UNINIT;
            life_reg.last_stamp_ms       <= '0;
            life_reg.init_error_count    <= '0;
            life_reg.measure_error_count <= '0;
            in_valid_reg                 <= 1'b0;
            out_valid_reg                <= 1'b0;
        end else begin
            if (advance) begin
                life_reg <= life_next;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_next;
        end
    end

endmodule
